// ===== hdl/tcpae_pkg.sv =====
`timescale 1ns / 1ps

package tcpae_pkg;

    // Outcome codes
    localparam logic [2:0] OUT_NONE      = 3'd0;
    localparam logic [2:0] OUT_V4        = 3'd1;
    localparam logic [2:0] OUT_V6        = 3'd2;
    localparam logic [2:0] OUT_EOL       = 3'd3;
    localparam logic [2:0] OUT_MALFORMED = 3'd4;
    localparam logic [2:0] OUT_PARTIAL   = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_V4_KIND   = 3'd0;
    localparam logic [2:0] CFG_V4_LENGTH = 3'd1;
    localparam logic [2:0] CFG_V6_KIND   = 3'd2;
    localparam logic [2:0] CFG_V6_LENGTH = 3'd3;
    localparam logic [2:0] CFG_V6_ENABLE = 3'd4;

    // Option kinds with fixed meaning
    localparam logic [7:0] KIND_EOL  = 8'd0;
    localparam logic [7:0] KIND_NOP  = 8'd1;
    localparam logic [7:0] MIN_SIZE  = 8'd2;

    // Byte positions inside an address option
    localparam logic [4:0] PORT_HI_INDEX    = 5'd2;
    localparam logic [4:0] PORT_LO_INDEX    = 5'd3;
    localparam logic [4:0] ADDR_FIRST_INDEX = 5'd4;
    localparam logic [4:0] V4_ADDR_END      = 5'd8;   // first index past 4 address bytes
    localparam logic [4:0] V6_ADDR_END      = 5'd20;  // first index past 16 address bytes
    localparam logic [4:0] INDEX_MAX        = 5'd31;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       first_byte;
        logic       last_byte;
        logic       area_empty;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [15:0] client_port;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [31:0] found_total;
        logic [31:0] missing_total;
    } out_item_t;

    // Settled area result passed from parser to output stage
    typedef struct packed {
        logic [2:0]  outcome;
        logic [15:0] client_port;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } area_result_t;

    typedef struct packed {
        logic [7:0] v4_kind;
        logic [4:0] v4_length;
        logic [7:0] v6_kind;
        logic [4:0] v6_length;
        logic       v6_enable;
    } cfg_t;

endpackage

// ===== hdl/tcpae_front.sv =====
`timescale 1ns / 1ps

module tcpae_front #(
    parameter int MAX_OPTION_AREA_BYTES = 40
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  tcpae_pkg::in_item_t     item,
    input  tcpae_pkg::cfg_t         cfg,
    output logic                    push,
    output tcpae_pkg::area_result_t result
);

    localparam int CNT_W = $clog2(MAX_OPTION_AREA_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OPTION_AREA_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_KIND,
        PH_SIZE,
        PH_BODY
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             capturing_reg, capturing_next;
    logic             is_v6_reg, is_v6_next;
    logic [4:0]       index_reg, index_next;
    logic [7:0]       remain_reg, remain_next;
    logic [7:0]       kind_reg, kind_next;
    logic [15:0]      port_reg, port_next;
    logic [127:0]     addr_reg, addr_next;

    logic       emit;
    logic [2:0] outc;
    logic       last;
    logic [7:0] b;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        capturing_next = capturing_reg;
        is_v6_next     = is_v6_reg;
        index_next     = index_reg;
        remain_next    = remain_reg;
        kind_next      = kind_reg;
        port_next      = port_reg;
        addr_next      = addr_reg;
        emit           = 1'b0;
        outc           = tcpae_pkg::OUT_NONE;
        last           = item.last_byte;
        b              = item.option_byte;

        if (accept)
        begin
            if (item.area_empty)
            begin
                capturing_next = 1'b0;
                is_v6_next     = 1'b0;
                index_next     = '0;
                remain_next    = '0;
                kind_next      = '0;
                port_next      = '0;
                addr_next      = '0;
                emit           = 1'b1;
                outc           = tcpae_pkg::OUT_NONE;
            end
            else if (item.first_byte || phase_reg != PH_IDLE)
            begin
                if (item.first_byte)
                begin
                    phase_next     = PH_KIND;
                    count_next     = '0;
                    capturing_next = 1'b0;
                    is_v6_next     = 1'b0;
                    index_next     = '0;
                    remain_next    = '0;
                    kind_next      = '0;
                    port_next      = '0;
                    addr_next      = '0;
                end
                count_next = count_next + 1'b1;
                if (count_next >= CNT_LAST)
                    last = 1'b1;

                unique case (phase_next)
                    PH_KIND:
                    begin
                        if (b == tcpae_pkg::KIND_EOL)
                        begin
                            emit = 1'b1;
                            outc = tcpae_pkg::OUT_EOL;
                        end
                        else if (b != tcpae_pkg::KIND_NOP)
                        begin
                            kind_next  = b;
                            phase_next = PH_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        if (b < tcpae_pkg::MIN_SIZE)
                        begin
                            emit = 1'b1;
                            outc = tcpae_pkg::OUT_MALFORMED;
                        end
                        else
                        begin
                            remain_next = b - tcpae_pkg::MIN_SIZE;
                            // IPv4 match wins over IPv6
                            if (kind_next == cfg.v4_kind && b == {3'b000, cfg.v4_length})
                            begin
                                capturing_next = 1'b1;
                                is_v6_next     = 1'b0;
                            end
                            else if (cfg.v6_enable && kind_next == cfg.v6_kind
                                     && b == {3'b000, cfg.v6_length})
                            begin
                                capturing_next = 1'b1;
                                is_v6_next     = 1'b1;
                            end
                            index_next = tcpae_pkg::PORT_HI_INDEX;
                            if (remain_next == '0)
                            begin
                                if (capturing_next)
                                begin
                                    emit = 1'b1;
                                    outc = is_v6_next ? tcpae_pkg::OUT_V6 : tcpae_pkg::OUT_V4;
                                end
                                else
                                    phase_next = PH_KIND;
                            end
                            else
                                phase_next = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        if (capturing_next)
                        begin
                            if (index_next == tcpae_pkg::PORT_HI_INDEX)
                                port_next[15:8] = b;
                            else if (index_next == tcpae_pkg::PORT_LO_INDEX)
                                port_next[7:0] = b;
                            else if (index_next >= tcpae_pkg::ADDR_FIRST_INDEX)
                            begin
                                if ((is_v6_next && index_next < tcpae_pkg::V6_ADDR_END)
                                    || (!is_v6_next && index_next < tcpae_pkg::V4_ADDR_END))
                                    addr_next = {addr_next[119:0], b};
                            end
                            if (index_next != tcpae_pkg::INDEX_MAX)
                                index_next = index_next + 1'b1;
                        end
                        if (remain_next != '0)
                            remain_next = remain_next - 1'b1;
                        if (remain_next == '0)
                        begin
                            if (capturing_next)
                            begin
                                emit = 1'b1;
                                outc = is_v6_next ? tcpae_pkg::OUT_V6 : tcpae_pkg::OUT_V4;
                            end
                            else
                                phase_next = PH_KIND;
                        end
                    end
                    PH_IDLE:
                    begin
                    end
                endcase

                if (!emit && last)
                begin
                    emit = 1'b1;
                    outc = (phase_next == PH_KIND) ? tcpae_pkg::OUT_NONE
                                                   : tcpae_pkg::OUT_PARTIAL;
                end
            end
            if (emit)
                phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        push                = emit;
        result.outcome      = outc;
        result.client_port  = '0;
        result.address_high = '0;
        result.address_low  = '0;
        if (outc == tcpae_pkg::OUT_V4)
        begin
            result.client_port = port_next;
            result.address_low = {32'd0, addr_next[31:0]};
        end
        else if (outc == tcpae_pkg::OUT_V6)
        begin
            result.client_port  = port_next;
            result.address_high = addr_next[127:64];
            result.address_low  = addr_next[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            capturing_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            capturing_reg <= capturing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_v6_reg  <= is_v6_next;
        index_reg  <= index_next;
        remain_reg <= remain_next;
        kind_reg   <= kind_next;
        port_reg   <= port_next;
        addr_reg   <= addr_next;
    end

endmodule

// ===== hdl/tcpae_queue.sv =====
`timescale 1ns / 1ps

module tcpae_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tcpae_pkg::area_result_t push_data,
    output logic                    space,
    input  logic                    pop,
    output logic                    avail,
    output tcpae_pkg::area_result_t pop_data
);

    localparam int DEPTH = tcpae_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tcpae_pkg::area_result_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign space    = (count_reg != CNT_FULL);
    assign avail    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hdl/tcpae_back.sv =====
`timescale 1ns / 1ps

module tcpae_back #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    avail,
    input  tcpae_pkg::area_result_t res,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tcpae_pkg::out_item_t    out_data
);

    logic [COUNTER_BITS-1:0] found_reg, found_next;
    logic [COUNTER_BITS-1:0] missing_reg, missing_next;
    logic                    valid_reg;
    tcpae_pkg::out_item_t    data_reg, data_next;
    logic                    found;
    logic [COUNTER_BITS+31:0] found_wide, missing_wide;

    assign pop   = avail && (!valid_reg || out_ready);
    assign found = (res.outcome == tcpae_pkg::OUT_V4) || (res.outcome == tcpae_pkg::OUT_V6);

    always_comb
    begin
        found_next   = found_reg;
        missing_next = missing_reg;
        if (pop)
        begin
            if (found)
                found_next = found_reg + 1'b1;
            else
                missing_next = missing_reg + 1'b1;
        end
        // report the low 32 bits, zero-extended when counters are narrower
        found_wide             = {32'd0, found_next};
        missing_wide           = {32'd0, missing_next};
        data_next.outcome      = res.outcome;
        data_next.client_port  = res.client_port;
        data_next.address_high = res.address_high;
        data_next.address_low  = res.address_low;
        data_next.found_total  = found_wide[31:0];
        data_next.missing_total = missing_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= '0;
            missing_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            found_reg   <= found_next;
            missing_reg <= missing_next;
            if (pop)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/tcp_option_address_extractor_top.sv =====
`timescale 1ns / 1ps

// Walks a TCP option area one byte per transfer and reports one result per area:
// the matching IPv4 or IPv6 address option (port and address), or why none was
// found, with running found/missing counts. One byte is taken every cycle while
// in_ready is high; the parser settles each byte combinationally, and each result
// is written into a two-entry result queue that sits between parser and output
// register, so in_ready drops only when both entries are held by a stalled output.
// Configuration writes are always taken (cfg_ready is high) and should be made
// while no area is in progress.
module tcp_option_address_extractor_top #(
    parameter int MAX_OPTION_AREA_BYTES = 40,
    parameter int COUNTER_BITS          = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcpae_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcpae_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data
);

    tcpae_pkg::cfg_t         cfg_reg;
    tcpae_pkg::area_result_t front_res;
    tcpae_pkg::area_result_t queue_res;
    logic                    push;
    logic                    space;
    logic                    avail;
    logic                    pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.v4_kind   <= 8'd254;
            cfg_reg.v4_length <= 5'd8;
            cfg_reg.v6_kind   <= 8'd253;
            cfg_reg.v6_length <= 5'd20;
            cfg_reg.v6_enable <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcpae_pkg::CFG_V4_KIND:   cfg_reg.v4_kind   <= cfg_data;
                tcpae_pkg::CFG_V4_LENGTH: cfg_reg.v4_length <= cfg_data[4:0];
                tcpae_pkg::CFG_V6_KIND:   cfg_reg.v6_kind   <= cfg_data;
                tcpae_pkg::CFG_V6_LENGTH: cfg_reg.v6_length <= cfg_data[4:0];
                tcpae_pkg::CFG_V6_ENABLE: cfg_reg.v6_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tcpae_front #(
        .MAX_OPTION_AREA_BYTES(MAX_OPTION_AREA_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_valid && space),
        .item   (in_data),
        .cfg    (cfg_reg),
        .push   (push),
        .result (front_res)
    );

    tcpae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_res),
        .space     (space),
        .pop       (pop),
        .avail     (avail),
        .pop_data  (queue_res)
    );

    tcpae_back #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .res       (queue_res),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
